// ----- rtl/sha_pkg.sv -----
package sha_pkg;

  typedef logic [31:0] word_t;

  // one queued command between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } cmd_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFS  = 6'd56;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ----- rtl/sha_cmd_fifo.sv -----
module sha_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  sha_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output sha_pkg::cmd_t rd_data,
  output logic          empty
);
  import sha_pkg::*;

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
    end
  end
endmodule

// ----- rtl/sha_ram.sv -----
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// ----- rtl/sha_engine.sv -----
module sha_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  sha_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          dig_valid,
  output logic [255:0]  dig,
  input  logic          dig_take
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]   st_r, st_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  len_r, len_nxt;
  logic [255:0] h_r, h_nxt;
  logic [255:0] v_r, v_nxt;
  word_t        w_r [16];
  logic [23:0]  acc_r;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         fin_r, fin_nxt;
  logic         pad_r, pad_nxt;        // 0x80 already written
  logic         len_ok_r, len_ok_nxt;  // length fits in the current block
  logic         done_r, done_nxt;      // length written, last block under way
  logic [63:0]  bits_r, bits_nxt;
  logic [60:0]  len_inc;
  logic [2:0]   len_sel;

  logic       we;
  logic [5:0] waddr, raddr;
  logic [7:0] wdata, rdata;

  sha_ram #(.WIDTH(8), .DEPTH(64)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // load reads address cnt, data arrives from the registered store output in the next cycle
  assign raddr   = cnt_r[5:0];
  assign len_inc = len_r + 61'd1;
  // length bytes go out most significant first at offsets 56 to 63
  assign len_sel = 3'd7 - fill_r[2:0];

  word_t a, b, c, d, e, f, g, hh, t1, t2, s0, s1, wn, wi;
  always_comb begin
    {a, b, c, d, e, f, g, hh} = v_r;
    wi = w_r[0];
    t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
       + round_k(cnt_r[5:0]) + wi;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
  end

  always_comb begin
    st_nxt     = st_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    h_nxt      = h_r;
    v_nxt      = v_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    pad_nxt    = pad_r;
    len_ok_nxt = len_ok_r;
    done_nxt   = done_r;
    bits_nxt   = bits_r;
    cmd_pop    = 1'b0;
    we         = 1'b0;
    waddr      = fill_r;
    wdata      = cmd.data;
    case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          fin_nxt = cmd.eom;
          if (cmd.present) begin
            we       = 1'b1;
            fill_nxt = fill_r + 1'b1;
            len_nxt  = len_inc;
          end
          if (cmd.eom) bits_nxt = {(cmd.present ? len_inc : len_r), 3'b000};
          if (cmd.present && fill_r == 6'd63) begin
            st_nxt  = S_LOAD;
            cnt_nxt = '0;
          end else if (cmd.eom) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        // 0x80 first, then zeros, length bytes from offset 56 when they fit
        we       = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (!pad_r) begin
          wdata      = PAD_BYTE;
          pad_nxt    = 1'b1;
          len_ok_nxt = (fill_r < LEN_OFS);
        end else if (len_ok_r && fill_r >= LEN_OFS) begin
          wdata = bits_r[{len_sel, 3'b000} +: 8];
        end else begin
          wdata = 8'h00;
        end
        if (fill_r == 6'd63) begin
          st_nxt   = S_LOAD;
          cnt_nxt  = '0;
          done_nxt = pad_r && len_ok_r;
        end
      end
      S_LOAD: begin
        // 64 byte reads from the registered store; shift in as words
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd64) begin
          v_nxt   = h_r;
          cnt_nxt = '0;
          st_nxt  = S_RND;
        end
      end
      S_RND: begin
        v_nxt   = {t1 + t2, a, b, c, d + t1, e, f, g};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd63) st_nxt = S_ADD;
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[32*i +: 32] = h_r[32*i +: 32] + v_r[32*i +: 32];
        end
        if (fin_r && done_r) st_nxt = S_OUT;
        else if (fin_r) begin
          // padding goes on in a fresh block
          st_nxt     = S_PAD;
          len_ok_nxt = 1'b1;
        end else st_nxt = S_IDLE;
      end
      S_OUT: begin
        if (dig_take) begin
          st_nxt     = S_IDLE;
          h_nxt      = INIT_HASH;
          len_nxt    = '0;
          fill_nxt   = '0;
          fin_nxt    = 1'b0;
          pad_nxt    = 1'b0;
          len_ok_nxt = 1'b0;
          done_nxt   = 1'b0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_LOAD && cnt_r != '0) begin
      // assemble big-endian words, shift one in every fourth byte
      acc_r <= {acc_r[15:0], rdata};
      if (cnt_r[1:0] == 2'd0) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= {acc_r, rdata};
      end
    end else if (st_r == S_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
    end
  end

  always_comb begin
    dig_valid = (st_r == S_OUT);
    dig       = h_r;
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    bits_r <= bits_nxt;
    if (!rst_n) begin
      st_r     <= S_IDLE;
      fill_r   <= '0;
      len_r    <= '0;
      h_r      <= INIT_HASH;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
      pad_r    <= 1'b0;
      len_ok_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      fill_r   <= fill_nxt;
      len_r    <= len_nxt;
      h_r      <= h_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      pad_r    <= pad_nxt;
      len_ok_r <= len_ok_nxt;
      done_r   <= done_nxt;
    end
  end
endmodule

// ----- rtl/sha256_message_digest_core.sv -----
// channel | dir | tdata (low bit up)            | tuser        | tlast
// in_     | in  | data_byte[7:0]                | byte_present | end_of_message
// out_    | out | digest_part[63:0]             | -            | part_last
//
// the engine takes bytes from the queue only while idle, not while padding or compressing
// every full block is read from the block store, then takes 64 rounds and 1 add
// end of message pads one byte per cycle to the block end, compresses one or
// two blocks, then the digest leaves as four words held while out_tready is low
// reset clears length, fill count and queue and loads the initial hash as chaining words
// a four entry command queue parts intake from compression; full drops in_tready
module sha256_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // digest_part
  output logic        out_tlast   // part_last
);
  import sha_pkg::*;

  cmd_t         q_in, q_out;
  logic         q_full, q_empty, q_pop;
  logic         dig_valid, dig_take;
  logic [255:0] dig;
  logic [1:0]   part_r;

  assign q_in      = '{data: in_tdata, present: in_tuser, eom: in_tlast};
  assign in_tready = !q_full;

  sha_cmd_fifo u_fifo (
    .clk, .rst_n, .wr_en(in_tvalid && in_tready), .wr_data(q_in), .full(q_full),
    .rd_en(q_pop), .rd_data(q_out), .empty(q_empty)
  );

  sha_engine u_eng (
    .clk, .rst_n, .cmd_valid(!q_empty), .cmd(q_out), .cmd_pop(q_pop),
    .dig_valid, .dig, .dig_take
  );

  // four parts, most significant first
  assign out_tvalid = dig_valid;
  assign out_tdata  = dig[255 - 64*part_r -: 64];
  assign out_tlast  = (part_r == 2'd3);
  assign dig_take   = out_tvalid && out_tready && out_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
    end else if (out_tvalid && out_tready) begin
      part_r <= part_r + 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_tlast_only_part3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> part_r == 2'd3) else $error("tlast misplaced");
  a_part_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> part_r == 2'd0) else $error("part counter stray");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue underflow");
`endif
endmodule
